// ===== hdl/rsz_pkg.sv =====
// ----------------------------------------------------------------------------
// rsz_pkg
// Shared types and constants for the rolling spread z-score block.
// ----------------------------------------------------------------------------
package rsz_pkg;

    localparam int WINDOW_DEF  = 8;
    localparam int PRICE_W     = 24;
    localparam int SPREAD_W    = 25;
    localparam int SUM_W       = 33;
    localparam int SQSUM_W     = 56;
    localparam int DIFF_W      = 34;
    localparam int DMAG_W      = 33;
    localparam int VAR_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int NUM_W       = DMAG_W + 16;
    localparam int Z_W         = 25;
    localparam int QUEUE_DEPTH = 2;

    // Score limits in Q8.16
    localparam logic [NUM_W-1:0] Z_MAX_POS = NUM_W'(24'hFF_FFFF);
    localparam logic [NUM_W-1:0] Z_MAX_NEG = NUM_W'(25'h100_0000);

    // One item handed from the front to the back
    typedef struct packed {
        logic              full;
        logic              flat;
        logic              neg;
        logic [DMAG_W-1:0] dmag;
        logic [VAR_W-1:0]  var_term;
    } rsz_job_t;

endpackage

// ===== hdl/rsz_front.sv =====
// ----------------------------------------------------------------------------
// rsz_front
// Accepts price pairs, keeps the spread window and running sums, and forms
// the deviation and variance terms of each item for the scoring back end.
// ----------------------------------------------------------------------------
module rsz_front #(
    parameter int WINDOW = rsz_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rsz_pkg::PRICE_W-1:0]    s_price_a,
    input  logic [rsz_pkg::PRICE_W-1:0]    s_price_b,
    output logic                           q_push,
    output rsz_pkg::rsz_job_t              q_data,
    input  logic                           q_full
);
    import rsz_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam logic signed [DIFF_W-1:0] WIN_S = DIFF_W'(WINDOW);
    localparam logic [VAR_W-1:0] WIN_U = VAR_W'(WINDOW);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CALC = 4'b0010,
        F_VAR  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [SPREAD_W-1:0] window_mem [WINDOW];

    logic [SLOT_W-1:0]         slot_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQSUM_W-1:0]        sqsum_reg;
    logic signed [SPREAD_W-1:0] spread_reg;
    logic signed [SPREAD_W-1:0] old_reg;
    logic                      full_reg;
    logic [47:0]               sq_reg;
    logic [47:0]               oldsq_reg;
    logic signed [DIFF_W-1:0]  d_reg;
    logic [VAR_W-1:0]          wq_reg;
    logic [33:0]               hh_reg;
    logic [32:0]               hl_reg;
    logic [31:0]               ll_reg;
    logic [VAR_W-1:0]          ssq_reg;

    logic [23:0]        smag;
    logic [23:0]        oldmag;
    logic [SUM_W-1:0]   sum_mag;
    logic [VAR_W-1:0]   var_term;
    logic [DIFF_W-1:0]  d_abs;

    assign s_ready = (state_reg == F_IDLE);

    // Magnitudes for the squaring multipliers and the deviation, and the variance term
    always_comb begin
        smag    = spread_reg[SPREAD_W-1] ? 24'(-spread_reg) : 24'(spread_reg);
        oldmag  = old_reg[SPREAD_W-1] ? 24'(-old_reg) : 24'(old_reg);
        sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        d_abs   = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
        var_term = wq_reg - ssq_reg;
    end

    // Job for the back end
    always_comb begin
        q_data.full     = full_reg;
        q_data.flat     = (var_term == '0);
        q_data.neg      = d_reg[DIFF_W-1];
        q_data.dmag     = d_abs[DMAG_W-1:0];
        q_data.var_term = var_term;
        q_push          = (state_reg == F_PUSH) && !q_full;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_valid) state_next = F_CALC;
            F_CALC: state_next = F_VAR;
            F_VAR:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Window store: read oldest slot on transfer, write new spread on push
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE) begin
            old_reg <= window_mem[slot_reg];
        end
        if (q_push) begin
            window_mem[slot_reg] <= spread_reg;
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            spread_reg <= $signed({1'b0, s_price_a}) - $signed({1'b0, s_price_b});
            full_reg   <= (fill_reg == FILL_W'(WINDOW));
        end
        if (state_reg == F_CALC) begin
            sq_reg    <= smag * smag;
            oldsq_reg <= oldmag * oldmag;
            d_reg     <= WIN_S * DIFF_W'(spread_reg) - DIFF_W'(sum_reg);
            wq_reg    <= WIN_U * VAR_W'(sqsum_reg);
            hh_reg    <= sum_mag[32:16] * sum_mag[32:16];
            hl_reg    <= sum_mag[32:16] * sum_mag[15:0];
            ll_reg    <= sum_mag[15:0] * sum_mag[15:0];
        end
        if (state_reg == F_VAR) begin
            ssq_reg <= (VAR_W'(hh_reg) << 32) + (VAR_W'(hl_reg) << 17) + VAR_W'(ll_reg);
        end
    end

    // Control state and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (q_push) begin
                if (full_reg) begin
                    sum_reg   <= sum_reg + SUM_W'(spread_reg) - SUM_W'(old_reg);
                    sqsum_reg <= sqsum_reg + SQSUM_W'(sq_reg) - SQSUM_W'(oldsq_reg);
                end else begin
                    sum_reg   <= sum_reg + SUM_W'(spread_reg);
                    sqsum_reg <= sqsum_reg + SQSUM_W'(sq_reg);
                    fill_reg  <= fill_reg + 1'b1;
                end
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rsz_queue.sv =====
// ----------------------------------------------------------------------------
// rsz_queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module rsz_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rsz_pkg::rsz_job_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output rsz_pkg::rsz_job_t pop_data
);
    import rsz_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    rsz_job_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W:0]      count_reg;

    assign full      = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rsz_back.sv =====
// ----------------------------------------------------------------------------
// rsz_back
// Scores one job at a time: digit-by-digit square root of the variance
// term, restoring division of the scaled deviation, then saturation.
// ----------------------------------------------------------------------------
module rsz_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_not_empty,
    input  rsz_pkg::rsz_job_t            q_data,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [rsz_pkg::Z_W-1:0] m_z_score,
    output logic                         m_z_valid,
    output logic                         m_flat_window,
    output logic                         m_saturated
);
    import rsz_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_SQRT = 5'b00010,
        B_DIV  = 5'b00100,
        B_FIN  = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic              neg_reg;
    logic [DMAG_W-1:0] dmag_reg;
    logic [VAR_W-1:0]  rad_reg;
    logic [33:0]       rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [ROOT_W-1:0] drem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [5:0]        cnt_reg;

    logic signed [Z_W-1:0] z_reg;
    logic                  zv_reg;
    logic                  flat_reg;
    logic                  sat_reg;

    logic [35:0]       sq_trial;
    logic [35:0]       sq_sub;
    logic              sq_take;
    logic [ROOT_W:0]   dv_trial;
    logic              dv_take;

    assign m_valid       = (state_reg == B_OUT);
    assign m_z_score     = z_reg;
    assign m_z_valid     = zv_reg;
    assign m_flat_window = flat_reg;
    assign m_saturated   = sat_reg;
    assign q_pop         = (state_reg == B_IDLE) && q_not_empty;

    // One root digit and one quotient bit per cycle
    always_comb begin
        sq_trial = {rem_reg, rad_reg[VAR_W-1 -: 2]};
        sq_sub   = {2'b00, root_reg, 2'b01};
        sq_take  = (sq_trial >= sq_sub);
        dv_trial = {drem_reg, num_reg[NUM_W-1]};
        dv_take  = (dv_trial >= {1'b0, root_reg});
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_not_empty) begin
                    state_next = (q_data.full && !q_data.flat) ? B_SQRT : B_OUT;
                end
            end
            B_SQRT: if (cnt_reg == '0) state_next = B_DIV;
            B_DIV:  if (cnt_reg == '0) state_next = B_FIN;
            B_FIN:  state_next = B_OUT;
            B_OUT:  if (m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                neg_reg  <= q_data.neg;
                dmag_reg <= q_data.dmag;
                rad_reg  <= q_data.var_term;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'(ROOT_W - 1);
                z_reg    <= '0;
                zv_reg   <= q_data.full;
                flat_reg <= q_data.full && q_data.flat;
                sat_reg  <= 1'b0;
            end
            B_SQRT: begin
                rad_reg <= rad_reg << 2;
                if (sq_take) begin
                    rem_reg  <= 34'(sq_trial - sq_sub);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= 34'(sq_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    num_reg  <= {dmag_reg, 16'b0};
                    drem_reg <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= 6'(NUM_W - 1);
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            B_DIV: begin
                num_reg <= num_reg << 1;
                quo_reg <= {quo_reg[NUM_W-2:0], dv_take};
                if (dv_take) begin
                    drem_reg <= ROOT_W'(dv_trial - {1'b0, root_reg});
                end else begin
                    drem_reg <= ROOT_W'(dv_trial);
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            B_FIN: begin
                // Clip to the Q8.16 range
                if (neg_reg) begin
                    if (quo_reg > Z_MAX_NEG) begin
                        z_reg   <= -Z_W'(Z_MAX_NEG);
                        sat_reg <= 1'b1;
                    end else begin
                        z_reg <= -Z_W'(quo_reg);
                    end
                end else begin
                    if (quo_reg > Z_MAX_POS) begin
                        z_reg   <= Z_W'(Z_MAX_POS);
                        sat_reg <= 1'b1;
                    end else begin
                        z_reg <= Z_W'(quo_reg);
                    end
                end
            end
            B_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/rolling_spread_zscore.sv =====
// ----------------------------------------------------------------------------
// rolling_spread_zscore
// Rolling z-score of a price spread against the previous WINDOW spreads.
// ----------------------------------------------------------------------------
// Input channel s_*: one price pair per transfer. Result channel m_*: one
// result per input, in order. The first WINDOW items only fill the window and
// return all-zero results with m_z_valid low; later items are scored.
// The front end steps through transfer, multiply, square sum and push for each
// item; its rate is set by the running-sum update, which must finish before
// the next item is taken. For a scored item the back end pops the job, forms
// the square root (one root digit a cycle), runs restoring division (one
// quotient bit a cycle), then clips and presents the result. Unscored items
// go from pop straight to output. The back end finishes each item before it
// pops the next, so it sets the sustained rate of scored items.
// A two-entry queue lets the front keep taking items while the back works
// or while a result waits for m_ready. When the receiver stalls, the result
// is held and the queue fills, after which s_ready stays low.
// Reset (aresetn low, synchronous) empties the window and clears all sums.
// ----------------------------------------------------------------------------
module rolling_spread_zscore #(
    parameter int WINDOW = rsz_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rsz_pkg::PRICE_W-1:0]    s_price_a,
    input  logic [rsz_pkg::PRICE_W-1:0]    s_price_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [rsz_pkg::Z_W-1:0] m_z_score,
    output logic                           m_z_valid,
    output logic                           m_flat_window,
    output logic                           m_saturated
);
    import rsz_pkg::*;

    rsz_job_t push_data;
    rsz_job_t pop_data;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;

    rsz_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_price_a (s_price_a),
        .s_price_b (s_price_b),
        .q_push    (q_push),
        .q_data    (push_data),
        .q_full    (q_full)
    );

    rsz_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    rsz_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_z_score     (m_z_score),
        .m_z_valid     (m_z_valid),
        .m_flat_window (m_flat_window),
        .m_saturated   (m_saturated)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("queue push while full");

    // Filling results carry no score and no flags
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_z_valid) |-> (m_z_score == '0 && !m_flat_window && !m_saturated))
        else $error("unscored result not zero");

    // A flat window forces a zero, unclipped score
    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_flat_window) |-> (m_z_score == '0 && !m_saturated && m_z_valid))
        else $error("flat window score not zero");

    // A clipped score sits at one of the range limits
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_z_score == Z_W'(Z_MAX_POS) || m_z_score == -Z_W'(Z_MAX_NEG)))
        else $error("saturated score off limit");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rolling_spread_zscore: a predictor tracks the spread
// window and running sums, works out each score, and a monitor compares every
// result transfer with the oldest pending score under random idling.
// ----------------------------------------------------------------------------
module tb;
    import rsz_pkg::*;

    localparam int WIN       = WINDOW_DEF;
    localparam int LIMIT_CYC = 900000;
    localparam logic signed [24:0] ZPOS = 25'sh0FF_FFFF;
    localparam logic signed [24:0] ZNEG = 25'sh100_0000;

    typedef struct packed {
        logic [PRICE_W-1:0] pa;
        logic [PRICE_W-1:0] pb;
    } price_pair_t;

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  zv;
        logic                  flat;
        logic                  sat;
    } score_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [PRICE_W-1:0] s_price_a = '0;
    logic [PRICE_W-1:0] s_price_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [Z_W-1:0] m_z_score;
    logic m_z_valid, m_flat_window, m_saturated;

    price_pair_t pending_pairs[$];
    score_t      score_queue[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_send = 1'b0;

    // Predictor state
    logic signed [SPREAD_W-1:0] win_spreads[WIN];
    int                         slot_ptr = 0;
    int                         held = 0;
    logic signed [63:0]         sum_s = 0;
    logic [63:0]                sum_q = 0;

    rolling_spread_zscore #(.WINDOW(WIN)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_price_a(s_price_a), .s_price_b(s_price_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_z_score(m_z_score), .m_z_valid(m_z_valid),
        .m_flat_window(m_flat_window), .m_saturated(m_saturated)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Score one price pair and advance the window
    function automatic score_t score_pair(price_pair_t p);
        score_t res;
        logic signed [63:0] spr, dev, old_s;
        logic [63:0] smag, var_t, rt, mag;
        res = '0;
        spr = $signed({40'd0, p.pa}) - $signed({40'd0, p.pb});
        if (held >= WIN) begin
            dev = WIN * spr - sum_s;
            smag = sum_s < 0 ? -sum_s : sum_s;
            var_t = WIN * sum_q - smag * smag;
            res.zv = 1'b1;
            if (var_t == 0) begin
                res.flat = 1'b1;
            end else begin
                rt = root_floor(var_t);
                mag = ((dev < 0 ? -dev : dev) << 16) / rt;
                if (dev < 0) begin
                    if (mag > 64'd16777216) begin
                        res.z = ZNEG;
                        res.sat = 1'b1;
                    end else begin
                        res.z = -$signed(mag[24:0]);
                    end
                end else begin
                    if (mag > 64'd16777215) begin
                        res.z = ZPOS;
                        res.sat = 1'b1;
                    end else begin
                        res.z = mag[24:0];
                    end
                end
            end
            // Widen the oldest spread with its sign before squaring
            old_s = win_spreads[slot_ptr];
            sum_s = sum_s - old_s;
            sum_q = sum_q - old_s * old_s;
        end else begin
            held++;
        end
        win_spreads[slot_ptr] = spr[SPREAD_W-1:0];
        sum_s = sum_s + spr;
        sum_q = sum_q + spr * spr;
        slot_ptr = (slot_ptr + 1) % WIN;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // Drive the input channel from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                score_queue.insert(score_queue.size(),
                                   score_pair('{s_price_a, s_price_b}));
            end
            if ((!s_valid || s_ready) ) begin
                if (pending_pairs.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_price_a <= pending_pairs[0].pa;
                    s_price_b <= pending_pairs[0].pb;
                    void'(pending_pairs.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer and toggle the ready
    always @(posedge aclk) begin
        score_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (score_queue.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_z_score), 32'd0);
                end else begin
                    want = score_queue.pop_front();
                    if (m_z_score !== want.z)
                        report_mismatch("z_score", 32'(m_z_score), 32'(want.z));
                    if (m_z_valid !== want.zv)
                        report_mismatch("z_valid", 32'(m_z_valid), 32'(want.zv));
                    if (m_flat_window !== want.flat)
                        report_mismatch("flat_window", 32'(m_flat_window),
                                        32'(want.flat));
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", 32'(m_saturated), 32'(want.sat));
                end
            end
        end
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        if (cycle_count > LIMIT_CYC) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic price_pair_t mk(logic [23:0] a, logic [23:0] b);
        return '{a, b};
    endfunction

    task automatic add_pair(logic [23:0] a, logic [23:0] b);
        pending_pairs.insert(pending_pairs.size(), mk(a, b));
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_valid || score_queue.size() > 0)
            @(posedge aclk);
    endtask

    // Random pairs: mostly prices near a base so scores stay in range
    task automatic add_random(int n);
        logic [23:0] base;
        int kind;
        base = 24'($urandom);
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            if (kind == 0)
                add_pair(24'($urandom), 24'($urandom));
            else if (kind == 1)
                add_pair(base, base);
            else
                add_pair(base + 24'($urandom_range(4095)),
                         base + 24'($urandom_range(4095)));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: fill window, flat window, extremes, saturation both ways
        for (int i = 0; i < WIN; i++) add_pair(24'd1000, 24'd1000);
        add_pair(24'd1000, 24'd1000);
        add_pair(24'hFFFFFF, 24'd0);
        add_pair(24'd0, 24'hFFFFFF);
        for (int i = 0; i < WIN; i++) add_pair(24'd5, 24'd5);
        add_pair(24'd6, 24'd5);
        add_pair(24'd4, 24'd5);
        add_pair(24'hFFFFFF, 24'hFFFFFF);
        add_pair(24'hAAAAAA, 24'h555555);
        add_pair(24'h555555, 24'hAAAAAA);
        wait_drained();
        // Pause with nothing outstanding, then the idling phases
        hold_send = 1'b1;
        repeat (20) @(posedge aclk);
        hold_send = 1'b0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            add_random(140);
            wait_drained();
        end
        recv_stall_pct = 0;
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
